// ----- hw/rtl/crr_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, codes and types for the chained range remapper.
// No dependencies; imported by the top level.
package crr_pkg;

    localparam int MAX_STAGES        = 8;
    localparam int ENTRIES_PER_STAGE = 64;
    localparam int VALUE_BITS        = 36;
    localparam int CFG_BITS          = 4;

    localparam int STAGE_W     = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
    localparam int STAGE_CNT_W = $clog2(MAX_STAGES + 1);
    localparam int COUNT_W     = $clog2(ENTRIES_PER_STAGE + 1);
    localparam int TABLE_DEPTH = MAX_STAGES * ENTRIES_PER_STAGE;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    localparam logic [CFG_BITS-1:0] STAGES_RESET = CFG_BITS'(7);
    localparam logic [VALUE_BITS-1:0] VALUE_ALL_ONES = '1;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_MAP   = 2'd1,
        OP_CLEAR = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_TABLE_FULL = 2'd1,
        ST_BAD_STAGE  = 2'd2,
        ST_SATURATED  = 2'd3
    } t_status;

    typedef struct packed {
        logic [VALUE_BITS-1:0] dest;
        logic [VALUE_BITS-1:0] source;
        logic [VALUE_BITS-1:0] length;
    } t_entry;

    localparam int ENTRY_BITS = $bits(t_entry);

endpackage

// ----- hw/rtl/chained_range_remap_min.sv -----
`timescale 1ns / 1ps
// Top level of the chained range remapper with running minimum.
// Depends on crr_pkg and crr_ram (the range entry table).
//
//  channel   direction  handshake                 payload
//  -------   ---------  ------------------------  ---------------------------------------
//  command   in         start & !busy             i_opcode, i_stage_index, i_dest_start,
//                                                 i_source_start, i_range_length,
//                                                 i_seed_value
//  result    out        o_result_valid (strobe)   o_mapped_value, o_running_min, o_status
//  config    in         i_cfg_valid & o_cfg_ready i_stages_in_use
//
// For load, clear and unused opcodes the result strobe is high in the cycle
// after the accepting edge and busy never rises. A map transaction walks the entry table
// through the one read port of the RAM: per stage, each entry that misses takes a read and a
// compare, the entry that hits takes a read, a compare and an add, and a stage without a hit
// is stepped past; a last step folds the value into the minimum. Busy falls and the result
// strobe rises at the same edge.
// Reset (synchronous, active low) empties every stage table, sets the minimum to all ones
// and stages_in_use to 7; the table contents themselves are not cleared. Busy is high while
// reset is asserted. The receiver cannot stall; each result is shown for exactly one cycle.
module chained_range_remap_min (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // command
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     i_opcode,
    input  logic [2:0]                     i_stage_index,
    input  logic [crr_pkg::VALUE_BITS-1:0] i_dest_start,
    input  logic [crr_pkg::VALUE_BITS-1:0] i_source_start,
    input  logic [crr_pkg::VALUE_BITS-1:0] i_range_length,
    input  logic [crr_pkg::VALUE_BITS-1:0] i_seed_value,
    // result
    output logic                           o_result_valid,
    output logic [crr_pkg::VALUE_BITS-1:0] o_mapped_value,
    output logic [crr_pkg::VALUE_BITS-1:0] o_running_min,
    output logic [1:0]                     o_status,
    // config
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [crr_pkg::CFG_BITS-1:0]   i_stages_in_use
);

    import crr_pkg::*;

    // IDLE takes commands; READ issues a table read, steps to the next stage or ends the map;
    // COMPARE checks the entry just read; APPLY adds the offset to the hit entry.
    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_COMPARE,
        S_APPLY
    } t_state;

    t_state                  r_state;
    logic [CFG_BITS-1:0]     r_stages_in_use;
    logic [COUNT_W-1:0]      r_count [MAX_STAGES];
    logic [VALUE_BITS-1:0]   r_min;

    // scan state
    logic [STAGE_CNT_W-1:0]  r_use;
    logic [STAGE_CNT_W-1:0]  r_s;
    logic [COUNT_W-1:0]      r_k;
    logic [VALUE_BITS-1:0]   r_v;
    logic                    r_sat;
    logic [VALUE_BITS-1:0]   r_off;
    logic [VALUE_BITS-1:0]   r_dst;

    // registered result
    logic                    r_result_valid;
    logic [VALUE_BITS-1:0]   r_mapped;
    logic [VALUE_BITS-1:0]   r_min_out;
    t_status                 r_status;

    // table port
    logic                    ram_we;
    logic [ADDR_W-1:0]       ram_waddr;
    t_entry                  ram_wdata;
    logic [ADDR_W-1:0]       ram_raddr;
    t_entry                  ram_rdata;
    logic [ENTRY_BITS-1:0]   ram_rdata_bits;

    // command decode
    logic                    cmd_fire;
    logic [STAGE_W-1:0]      ld_stage;
    logic                    ld_bad_stage;
    logic                    ld_full;
    logic [COUNT_W-1:0]      ld_count;
    logic [STAGE_CNT_W-1:0]  n_use;

    // scan datapath
    logic [STAGE_W-1:0]      scan_stage;
    logic [COUNT_W-1:0]      scan_count;
    logic                    scan_stage_done;
    logic                    scan_all_done;
    logic [VALUE_BITS-1:0]   cmp_off;
    logic                    cmp_hit;
    logic [VALUE_BITS:0]     apply_sum;
    logic [VALUE_BITS-1:0]   fold_min;

    // Hold off commands and register writes while a map runs or reset is asserted.
    assign busy           = (r_state != S_IDLE) || !i_rst_n;
    assign o_cfg_ready    = !busy;
    assign cmd_fire       = start && !busy;

    assign o_result_valid = r_result_valid;
    assign o_mapped_value = r_mapped;
    assign o_running_min  = r_min_out;
    assign o_status       = r_status;

    // Load checks: stage in use first, then the table-full check. A 3-bit stage index
    // never reaches MAX_STAGES, so the in-use check covers both limits.
    assign ld_stage     = STAGE_W'(i_stage_index);
    assign ld_bad_stage = ({1'b0, i_stage_index} >= r_stages_in_use);
    assign ld_count     = r_count[ld_stage];
    assign ld_full      = (ld_count >= COUNT_W'(ENTRIES_PER_STAGE));

    // Clamp the stage count to the number of tables.
    assign n_use = (32'(r_stages_in_use) > 32'(MAX_STAGES)) ? STAGE_CNT_W'(MAX_STAGES)
                                                           : STAGE_CNT_W'(r_stages_in_use);

    assign ram_we         = cmd_fire && (i_opcode == OP_LOAD) && !ld_bad_stage && !ld_full;
    assign ram_waddr      = ADDR_W'(ld_stage) * ADDR_W'(ENTRIES_PER_STAGE) + ADDR_W'(ld_count);
    assign ram_wdata.dest   = i_dest_start;
    assign ram_wdata.source = i_source_start;
    assign ram_wdata.length = i_range_length;

    assign scan_stage      = r_s[STAGE_W-1:0];
    assign scan_count      = r_count[scan_stage];
    assign scan_all_done   = (r_s >= r_use);
    assign scan_stage_done = (r_k >= scan_count);
    assign ram_raddr       = ADDR_W'(scan_stage) * ADDR_W'(ENTRIES_PER_STAGE) + ADDR_W'(r_k);

    assign ram_rdata      = t_entry'(ram_rdata_bits);
    assign cmp_off        = r_v - ram_rdata.source;
    assign cmp_hit        = (r_v >= ram_rdata.source) && (cmp_off < ram_rdata.length);
    assign apply_sum      = {1'b0, r_dst} + {1'b0, r_off};
    assign fold_min       = (r_v < r_min) ? r_v : r_min;

    crr_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata_bits)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_stages_in_use <= STAGES_RESET;
            r_min           <= VALUE_ALL_ONES;
            r_result_valid  <= 1'b0;
            for (int i = 0; i < MAX_STAGES; i++) begin
                r_count[i] <= '0;
            end
        end else begin
            // strobe lasts one cycle
            r_result_valid <= 1'b0;

            if (i_cfg_valid && o_cfg_ready) begin
                r_stages_in_use <= i_stages_in_use;
            end

            case (r_state)
                S_IDLE: begin
                    if (cmd_fire) begin
                        r_mapped  <= '0;
                        r_min_out <= r_min;
                        r_status  <= ST_OK;
                        case (i_opcode)
                            OP_LOAD: begin
                                r_result_valid <= 1'b1;
                                if (ld_bad_stage) begin
                                    r_status <= ST_BAD_STAGE;
                                end else if (ld_full) begin
                                    r_status <= ST_TABLE_FULL;
                                end else begin
                                    r_count[ld_stage] <= ld_count + COUNT_W'(1);
                                end
                            end
                            OP_MAP: begin
                                r_v     <= i_seed_value;
                                r_sat   <= 1'b0;
                                r_s     <= '0;
                                r_k     <= '0;
                                r_use   <= n_use;
                                r_state <= S_READ;
                            end
                            OP_CLEAR: begin
                                r_result_valid <= 1'b1;
                                r_min          <= VALUE_ALL_ONES;
                                r_min_out      <= VALUE_ALL_ONES;
                                for (int i = 0; i < MAX_STAGES; i++) begin
                                    r_count[i] <= '0;
                                end
                            end
                            default: begin
                                // unused opcode: report, change nothing
                                r_result_valid <= 1'b1;
                            end
                        endcase
                    end
                end
                S_READ: begin
                    if (scan_all_done) begin
                        // fold into the minimum and report
                        r_min          <= fold_min;
                        r_min_out      <= fold_min;
                        r_mapped       <= r_v;
                        r_status       <= r_sat ? ST_SATURATED : ST_OK;
                        r_result_valid <= 1'b1;
                        r_state        <= S_IDLE;
                    end else if (scan_stage_done) begin
                        // no entry hit: value passes this stage unchanged
                        r_s <= r_s + STAGE_CNT_W'(1);
                        r_k <= '0;
                    end else begin
                        r_state <= S_COMPARE;
                    end
                end
                S_COMPARE: begin
                    if (cmp_hit) begin
                        r_off   <= cmp_off;
                        r_dst   <= ram_rdata.dest;
                        r_state <= S_APPLY;
                    end else begin
                        r_k     <= r_k + COUNT_W'(1);
                        r_state <= S_READ;
                    end
                end
                S_APPLY: begin
                    // saturate on carry out of the value range
                    if (apply_sum[VALUE_BITS]) begin
                        r_v   <= VALUE_ALL_ONES;
                        r_sat <= 1'b1;
                    end else begin
                        r_v <= apply_sum[VALUE_BITS-1:0];
                    end
                    r_s     <= r_s + STAGE_CNT_W'(1);
                    r_k     <= '0;
                    r_state <= S_READ;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- hw/rtl/crr_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module crr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- tb/sv/tb_chained_range_remap_min.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for chained_range_remap_min: sends load, map, clear and unused
// commands, rewrites the stage count between phases, predicts and checks every result.
// Depends on crr_pkg and the chained_range_remap_min RTL.
module tb_chained_range_remap_min;
    import crr_pkg::*;

    // Opcode 3 has no member in the package enum; the block must treat it as a no-op.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Leave a wide margin over the longest map across eight full stages plus the longest
    // sender gap.
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int MAX_GAP        = 40;
    localparam int ROUND_ITEMS    = 58;

    typedef struct packed {
        logic [1:0]            opcode;
        logic [2:0]            stage;
        logic [VALUE_BITS-1:0] dest;
        logic [VALUE_BITS-1:0] src;
        logic [VALUE_BITS-1:0] len;
        logic [VALUE_BITS-1:0] seed;
    } t_remap_cmd;

    typedef struct packed {
        logic [VALUE_BITS-1:0] mapped;
        logic [VALUE_BITS-1:0] run_min;
        logic [1:0]            status;
    } t_remap_out;

    // ------------------------------------------------------------------
    // Clock, reset and block ports; every input starts at a known value
    // ------------------------------------------------------------------
    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  start           = 1'b0;
    logic                  busy;
    logic [1:0]            i_opcode        = '0;
    logic [2:0]            i_stage_index   = '0;
    logic [VALUE_BITS-1:0] i_dest_start    = '0;
    logic [VALUE_BITS-1:0] i_source_start  = '0;
    logic [VALUE_BITS-1:0] i_range_length  = '0;
    logic [VALUE_BITS-1:0] i_seed_value    = '0;
    logic                  o_result_valid;
    logic [VALUE_BITS-1:0] o_mapped_value;
    logic [VALUE_BITS-1:0] o_running_min;
    logic [1:0]            o_status;
    logic                  i_cfg_valid     = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_BITS-1:0]   i_stages_in_use = '0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    chained_range_remap_min i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_opcode       (i_opcode),
        .i_stage_index  (i_stage_index),
        .i_dest_start   (i_dest_start),
        .i_source_start (i_source_start),
        .i_range_length (i_range_length),
        .i_seed_value   (i_seed_value),
        .o_result_valid (o_result_valid),
        .o_mapped_value (o_mapped_value),
        .o_running_min  (o_running_min),
        .o_status       (o_status),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_stages_in_use(i_stages_in_use)
    );

    // ------------------------------------------------------------------
    // Predictor state: the stage tables, their fill levels, the minimum
    // and the stage count as the block should hold them
    // ------------------------------------------------------------------
    logic [VALUE_BITS-1:0] tbl_dest [MAX_STAGES][ENTRIES_PER_STAGE];
    logic [VALUE_BITS-1:0] tbl_src  [MAX_STAGES][ENTRIES_PER_STAGE];
    logic [VALUE_BITS-1:0] tbl_len  [MAX_STAGES][ENTRIES_PER_STAGE];
    int unsigned           tbl_fill [MAX_STAGES];
    logic [VALUE_BITS-1:0] model_min;
    logic [CFG_BITS-1:0]   model_stages;

    t_remap_out remap_results_due[$];

    int sender_idle_pct = 0;
    int n_errors        = 0;
    int n_checked       = 0;
    int n_loads         = 0;
    int n_maps          = 0;
    int n_clears        = 0;
    int n_unused        = 0;
    int n_cfg_writes    = 0;
    int n_saturated     = 0;
    int n_full          = 0;
    int n_bad_stage     = 0;
    int quiet_cycles    = 0;

    // Apply one accepted command to the predictor and return the result it must produce.
    function automatic t_remap_out apply_command(t_remap_cmd c);
        t_remap_out            r;
        logic [VALUE_BITS-1:0] v;
        logic [VALUE_BITS:0]   sum;
        logic                  hit;
        int                    n_use;
        int                    s;
        int                    k;
        r        = '0;
        r.status = ST_OK;
        case (c.opcode)
            OP_LOAD: begin
                // The stage-in-use check wins over the full check.
                if (c.stage >= model_stages) begin
                    r.status = ST_BAD_STAGE;
                end else if (tbl_fill[c.stage] >= ENTRIES_PER_STAGE) begin
                    r.status = ST_TABLE_FULL;
                end else begin
                    tbl_dest[c.stage][tbl_fill[c.stage]] = c.dest;
                    tbl_src[c.stage][tbl_fill[c.stage]]  = c.src;
                    tbl_len[c.stage][tbl_fill[c.stage]]  = c.len;
                    tbl_fill[c.stage]++;
                end
            end
            OP_MAP: begin
                v     = c.seed;
                n_use = (model_stages > MAX_STAGES) ? MAX_STAGES : int'(model_stages);
                for (s = 0; s < n_use; s++) begin
                    hit = 1'b0;
                    // First loaded entry that covers v wins; zero length never covers.
                    for (k = 0; k < tbl_fill[s] && !hit; k++) begin
                        if (v >= tbl_src[s][k] && (v - tbl_src[s][k]) < tbl_len[s][k]) begin
                            hit = 1'b1;
                            sum = {1'b0, tbl_dest[s][k]} + (v - tbl_src[s][k]);
                            if (sum > {1'b0, VALUE_ALL_ONES}) begin
                                v        = VALUE_ALL_ONES;
                                r.status = ST_SATURATED;
                            end else begin
                                v = sum[VALUE_BITS-1:0];
                            end
                        end
                    end
                end
                if (v < model_min) model_min = v;
                r.mapped = v;
            end
            OP_CLEAR: begin
                for (s = 0; s < MAX_STAGES; s++) tbl_fill[s] = 0;
                model_min = VALUE_ALL_ONES;
            end
            default: ;
        endcase
        r.run_min = model_min;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Random field helpers: values cluster low so ranges chain between
    // stages, with full-width and near-top values for overflow and bit toggling
    // ------------------------------------------------------------------
    function automatic logic [VALUE_BITS-1:0] pick_value();
        logic [63:0]           raw;
        int unsigned           kind;
        logic [VALUE_BITS-1:0] v;
        raw  = {$urandom, $urandom};
        kind = $urandom_range(9);
        if (kind < 6)      v = VALUE_BITS'(raw[11:0]);
        else if (kind < 8) v = raw[VALUE_BITS-1:0];
        else               v = VALUE_ALL_ONES - VALUE_BITS'(raw[11:0]);
        return v;
    endfunction

    function automatic logic [VALUE_BITS-1:0] pick_length();
        logic [63:0]           raw;
        int unsigned           sel;
        logic [VALUE_BITS-1:0] len;
        raw = {$urandom, $urandom};
        sel = $urandom_range(99);
        if (sel < 8)       len = '0;
        else if (sel < 65) len = VALUE_BITS'($urandom_range(1, 4095));
        else               len = raw[VALUE_BITS-1:0];
        return len;
    endfunction

    // Mostly land inside a stage-0 entry so the chain actually remaps.
    function automatic logic [VALUE_BITS-1:0] pick_seed();
        logic [63:0]           raw;
        logic [63:0]           off;
        int unsigned           k;
        logic [VALUE_BITS-1:0] v;
        raw = {$urandom, $urandom};
        v   = pick_value();
        if (tbl_fill[0] > 0 && $urandom_range(99) < 70) begin
            k = $urandom_range(tbl_fill[0] - 1);
            if (tbl_len[0][k] != '0) begin
                off = raw % 64'(tbl_len[0][k]);
                v   = tbl_src[0][k] + off[VALUE_BITS-1:0];
            end
        end
        return v;
    endfunction

    function automatic t_remap_cmd random_cmd();
        t_remap_cmd  c;
        logic [63:0] raw;
        raw      = {$urandom, $urandom};
        c.opcode = 2'($urandom_range(3));
        c.stage  = 3'($urandom_range(7));
        c.dest   = raw[VALUE_BITS-1:0];
        raw      = {$urandom, $urandom};
        c.src    = raw[VALUE_BITS-1:0];
        raw      = {$urandom, $urandom};
        c.len    = raw[VALUE_BITS-1:0];
        raw      = {$urandom, $urandom};
        c.seed   = raw[VALUE_BITS-1:0];
        return c;
    endfunction

    function automatic t_remap_cmd make_load(logic [2:0] stage, logic [VALUE_BITS-1:0] dest,
                                             logic [VALUE_BITS-1:0] src,
                                             logic [VALUE_BITS-1:0] len);
        t_remap_cmd c;
        c        = random_cmd();
        c.opcode = OP_LOAD;
        c.stage  = stage;
        c.dest   = dest;
        c.src    = src;
        c.len    = len;
        return c;
    endfunction

    function automatic t_remap_cmd make_op(logic [1:0] opcode, logic [VALUE_BITS-1:0] seed);
        t_remap_cmd c;
        c        = random_cmd();
        c.opcode = opcode;
        c.seed   = seed;
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Command driver: optional idle gap, then hold start until the block
    // takes the transaction. Start stays high on return so back-to-back
    // commands need no second assignment in the same step.
    // ------------------------------------------------------------------
    task automatic send_command(t_remap_cmd c);
        t_remap_out r;
        int         gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct) gap++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_opcode       <= c.opcode;
        i_stage_index  <= c.stage;
        i_dest_start   <= c.dest;
        i_source_start <= c.src;
        i_range_length <= c.len;
        i_seed_value   <= c.seed;
        do @(posedge i_clk); while (busy !== 1'b0);
        r = apply_command(c);
        remap_results_due.insert(remap_results_due.size(), r);
        case (c.opcode)
            OP_LOAD:  n_loads++;
            OP_MAP:   n_maps++;
            OP_CLEAR: n_clears++;
            default:  n_unused++;
        endcase
        case (r.status)
            ST_SATURATED:  n_saturated++;
            ST_TABLE_FULL: n_full++;
            ST_BAD_STAGE:  n_bad_stage++;
            default: ;
        endcase
    endtask

    // Drop start and hold off until every outstanding result has been checked.
    task automatic wait_idle();
        start <= 1'b0;
        while (remap_results_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register writes happen only with the block idle.
    task automatic write_stage_count(logic [CFG_BITS-1:0] value);
        wait_idle();
        i_cfg_valid     <= 1'b1;
        i_stages_in_use <= value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid  <= 1'b0;
        model_stages = value;
        n_cfg_writes++;
    endtask

    // ------------------------------------------------------------------
    // Result checker: every strobe must match the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        t_remap_out want;
        if (i_rst_n && o_result_valid === 1'b1) begin
            if (remap_results_due.size() == 0) begin
                $display("%0t: unexpected result mapped %h min %h status %0d", $time,
                         o_mapped_value, o_running_min, o_status);
                n_errors++;
            end else begin
                want = remap_results_due.pop_front();
                n_checked++;
                if (o_mapped_value !== want.mapped) begin
                    $display("%0t: mapped_value expected %h, got %h", $time, want.mapped,
                             o_mapped_value);
                    n_errors++;
                end
                if (o_running_min !== want.run_min) begin
                    $display("%0t: running_min expected %h, got %h", $time, want.run_min,
                             o_running_min);
                    n_errors++;
                end
                if (o_status !== want.status) begin
                    $display("%0t: status expected %0d, got %0d", $time, want.status,
                             o_status);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog: abort when no transaction of any kind moves for too long.
    always @(posedge i_clk) begin
        if ((start && busy === 1'b0) || o_result_valid === 1'b1 ||
            (i_cfg_valid && o_cfg_ready === 1'b1)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog expired, %0d results still outstanding", $time,
                         remap_results_due.size());
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset state (seven stages in use): unused opcode, empty-table map, zero length,
    // overlapping entries, saturation carried into a later stage, stage not in use, clear.
    task automatic test_directed();
        send_command(make_op(OP_UNUSED, VALUE_ALL_ONES));
        send_command(make_op(OP_MAP, VALUE_ALL_ONES));
        send_command(make_load(3'd0, 36'd100, 36'd10, 36'd0));
        send_command(make_load(3'd0, 36'd1000, 36'd10, 36'd5));
        send_command(make_load(3'd0, 36'd0, 36'd12, 36'd100));
        send_command(make_load(3'd1, VALUE_ALL_ONES - 36'd2, 36'd1000, 36'd10));
        send_command(make_load(3'd7, 36'd1, 36'd1, 36'd1));
        send_command(make_load(3'd6, 36'd0, VALUE_ALL_ONES, 36'd1));
        send_command(make_load(3'd5, VALUE_ALL_ONES, 36'd0, VALUE_ALL_ONES));
        send_command(make_op(OP_MAP, 36'd10));
        send_command(make_op(OP_MAP, 36'd14));
        send_command(make_op(OP_MAP, 36'd12));
        send_command(make_op(OP_MAP, 36'd15));
        send_command(make_op(OP_MAP, 36'd0));
        send_command(make_op(OP_MAP, VALUE_ALL_ONES - 36'd1));
        send_command(make_op(OP_CLEAR, 36'd0));
        send_command(make_op(OP_MAP, 36'd10));
        send_command(make_op(OP_UNUSED, 36'd0));
    endtask

    // Stage count at its extremes: zero applies no stage, above eight acts as eight.
    task automatic test_stage_limits();
        write_stage_count(4'd0);
        send_command(make_load(3'd0, 36'd5, 36'd100, 36'd10));
        send_command(make_op(OP_MAP, 36'd103));
        write_stage_count(4'd15);
        send_command(make_op(OP_CLEAR, 36'd0));
        send_command(make_load(3'd7, 36'd5, 36'd100, 36'd10));
        send_command(make_op(OP_MAP, 36'd103));
        write_stage_count(4'd8);
        send_command(make_op(OP_MAP, 36'd109));
        send_command(make_op(OP_MAP, 36'd110));
        write_stage_count(4'd1);
        send_command(make_load(3'd1, 36'd0, 36'd0, 36'd1));
        send_command(make_op(OP_MAP, 36'd104));
    endtask

    // Fill stage 1 to the brim, overflow it, scan to its last entry, then shrink the
    // stage count so the out-of-use check must win over the full check.
    task automatic test_table_full();
        logic [VALUE_BITS-1:0] lo;
        int                    k;
        sender_idle_pct = 0;
        write_stage_count(4'd2);
        send_command(make_op(OP_CLEAR, 36'd0));
        for (k = 0; k <= ENTRIES_PER_STAGE; k++) begin
            lo = VALUE_BITS'(k * 16);
            send_command(make_load(3'd1, pick_value(), lo, 36'd16));
        end
        send_command(make_op(OP_MAP, VALUE_BITS'((ENTRIES_PER_STAGE - 1) * 16 + 5)));
        send_command(make_op(OP_MAP, VALUE_BITS'(ENTRIES_PER_STAGE * 16)));
        write_stage_count(4'd1);
        send_command(make_load(3'd1, 36'd0, 36'd0, 36'd1));
        send_command(make_op(OP_MAP, 36'd21));
    endtask

    // One random phase: fresh tables, mostly well-formed load/map traffic with random
    // content, plus noise (loads to any stage, unused opcode, stray clears).
    task automatic test_random_round(logic [CFG_BITS-1:0] stages, int idle_pct);
        t_remap_cmd  c;
        int unsigned sel;
        int          live;
        int          i;
        write_stage_count(stages);
        sender_idle_pct = idle_pct;
        live = (stages > MAX_STAGES) ? MAX_STAGES : int'(stages);
        send_command(make_op(OP_CLEAR, 36'd0));
        for (i = 0; i < ROUND_ITEMS; i++) begin
            c   = random_cmd();
            sel = $urandom_range(99);
            if (sel < 32 && live > 0) begin
                c = make_load(3'($urandom_range(live - 1)), pick_value(), pick_value(),
                              pick_length());
            end else if (sel < 82) begin
                c.opcode = OP_MAP;
                if ($urandom_range(9) != 0) c.seed = pick_seed();
            end else if (sel < 90) begin
                c.opcode = OP_LOAD;
            end else if (sel < 97) begin
                c.opcode = OP_UNUSED;
            end else begin
                c.opcode = OP_CLEAR;
            end
            send_command(c);
        end
    endtask

    initial begin
        for (int s = 0; s < MAX_STAGES; s++) tbl_fill[s] = 0;
        model_min    = VALUE_ALL_ONES;
        model_stages = STAGES_RESET;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_stage_limits();
        test_table_full();
        // Phases: no idling, heavy sender idling, light idling; stage counts reach
        // both ends of the register range, zero and fifteen (above the stage limit).
        test_random_round(4'd8, 0);
        test_random_round(4'd3, 62);
        test_random_round(4'd15, 12);
        test_random_round(4'd1, 0);
        test_random_round(4'd0, 62);
        test_random_round(4'd6, 12);
        wait_idle();

        $display("Covered %0d loads, %0d maps, %0d clears, %0d unused opcodes,",
                 n_loads, n_maps, n_clears, n_unused);
        $display("%0d stage-count writes; checked %0d results: %0d saturated, %0d full, %0d %s",
                 n_cfg_writes, n_checked, n_saturated, n_full, n_bad_stage,
                 "stage not in use.");
        if (n_errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- chained_range_remap_min.f -----
hw/rtl/crr_pkg.sv
hw/rtl/crr_ram.sv
hw/rtl/chained_range_remap_min.sv
tb/sv/tb_chained_range_remap_min.sv
